// ===== rtl/hspct_pkg.sv =====
// Shared widths, codes and types of the hard-sphere pair collision time block.
`timescale 1ns / 1ps
package hspct_pkg;

  localparam int IDX_W  = 8;
  localparam int DAT_W  = 32;
  localparam int VEC_W  = 3 * DAT_W;
  localparam int LEN_W  = 31;
  localparam int RAD_W  = 30;
  localparam int CFG_W  = 31;
  localparam int FRAC_W = 16;

  localparam int DX_W   = 34;
  localparam int DV_W   = 33;
  localparam int XV_W   = 67;
  localparam int VV_W   = 66;
  localparam int XX_W   = 68;
  localparam int SUM_W  = 70;
  localparam int AV_W   = 67;
  localparam int FA_W   = 2 * RAD_W + 2;

  localparam int LIMB_W = 23;
  localparam int NLIMB  = 3;
  localparam int OP_W   = LIMB_W * NLIMB;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int ROW_W  = 93;
  localparam int SQ_W   = 139;
  localparam int Q_W    = 140;

  localparam int M_W    = OP_W + FRAC_W;
  localparam int RT_W   = 85;
  localparam int RADC_W = 2 * RT_W;
  localparam int REM_W  = RT_W + 4;
  localparam int S_W    = RT_W + 1;
  localparam int N_W    = S_W + 1;
  localparam int MAG_W  = S_W;
  localparam int DREM_W = AV_W + 1;
  localparam int QUO_W  = MAG_W + 1;
  localparam int T_W    = 48;

  localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_BOX_LENGTH    = 1'b0,
    REG_SPHERE_RADIUS = 1'b1
  } reg_e;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
  } meta_t;

endpackage

// ===== rtl/hspct_store.sv =====
// Particle store: position and velocity memories, one write port, two registered read ports.
`timescale 1ns / 1ps
module hspct_store #(
  parameter int MAX_PARTICLES = 256,
  parameter int AW = 8
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [hspct_pkg::VEC_W-1:0] pos_i,
  input  logic [hspct_pkg::VEC_W-1:0] vel_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [hspct_pkg::VEC_W-1:0] pos_a_o,
  output logic [hspct_pkg::VEC_W-1:0] pos_b_o,
  output logic [hspct_pkg::VEC_W-1:0] vel_a_o,
  output logic [hspct_pkg::VEC_W-1:0] vel_b_o
);
  import hspct_pkg::*;

  logic [VEC_W-1:0] pos_mem [MAX_PARTICLES];
  logic [VEC_W-1:0] vel_mem [MAX_PARTICLES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pos_mem[waddr_i] <= pos_i;
      vel_mem[waddr_i] <= vel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_a_o <= pos_mem[raddr_a_i];
      pos_b_o <= pos_mem[raddr_b_i];
      vel_a_o <= vel_mem[raddr_a_i];
      vel_b_o <= vel_mem[raddr_b_i];
    end
  end

endmodule

// ===== rtl/hspct_geom.sv =====
// Pair geometry pipeline: separation, minimum image, dot products and discriminant.
`timescale 1ns / 1ps
module hspct_geom (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  hspct_pkg::meta_t                  meta_i,
  input  logic [hspct_pkg::VEC_W-1:0]       pos_a_i,
  input  logic [hspct_pkg::VEC_W-1:0]       pos_b_i,
  input  logic [hspct_pkg::VEC_W-1:0]       vel_a_i,
  input  logic [hspct_pkg::VEC_W-1:0]       vel_b_i,
  input  logic [hspct_pkg::LEN_W-1:0]       box_length_i,
  input  logic [hspct_pkg::RAD_W-1:0]       sphere_radius_i,
  output hspct_pkg::meta_t                  meta_o,
  output logic signed [hspct_pkg::Q_W-1:0]  q_o,
  output logic [hspct_pkg::M_W-1:0]         m_o,
  output logic [hspct_pkg::AV_W-1:0]        av_o
);
  import hspct_pkg::*;

  localparam int NST    = 9;
  localparam int ST_NEG = 4;

  meta_t meta_q [NST];
  meta_t meta_d [NST];

  logic signed [DV_W-1:0]  dx_q [3];
  logic signed [DV_W-1:0]  dv_q [3];
  logic signed [DX_W-1:0]  x_q [3];
  logic signed [DV_W-1:0]  v_q [3];
  logic signed [XV_W-1:0]  xv_q [3];
  logic signed [VV_W-1:0]  vv_q [3];
  logic signed [XX_W-1:0]  xxp_q [3];
  logic [FA_W-1:0]         fa_q;
  logic signed [SUM_W-1:0] p_q;
  logic signed [SUM_W-1:0] c_q;
  logic [AV_W-1:0]         av5_q;
  logic [OP_W-1:0]         pm_q;
  logic [OP_W-1:0]         cm_q;
  logic [OP_W-1:0]         avx_q;
  logic                    cneg_q [4];
  logic [PP_W-1:0]         pp_q [NLIMB][NLIMB];
  logic [PP_W-1:0]         ac_q [NLIMB][NLIMB];
  logic [ROW_W-1:0]        rowp_q [NLIMB];
  logic [ROW_W-1:0]        rowa_q [NLIMB];
  logic [SQ_W-1:0]         p2_q;
  logic [SQ_W-1:0]         avc_q;
  logic signed [Q_W-1:0]   q_q;
  logic [OP_W-1:0]         pm_pipe_q [4];
  logic [AV_W-1:0]         av_pipe_q [4];

  logic signed [DX_W-1:0]  x0 [3];
  logic signed [DX_W-1:0]  x1 [3];
  logic signed [DX_W-1:0]  x2 [3];
  logic signed [DX_W:0]    len2;
  logic signed [DX_W-1:0]  len1;
  logic [2*RAD_W-1:0]      aa;
  logic [ROW_W-1:0]        rowp_d [NLIMB];
  logic [ROW_W-1:0]        rowa_d [NLIMB];
  logic [SQ_W-1:0]         p2_d;
  logic [SQ_W-1:0]         avc_d;

  always_comb begin
    len2 = $signed((DX_W+1)'(box_length_i));
    len1 = $signed(DX_W'(box_length_i));
    for (int d = 0; d < 3; d++) begin
      x0[d] = DX_W'(dx_q[d]);
      x1[d] = x0[d];
      if ($signed({x0[d], 1'b0}) > len2) x1[d] = x0[d] - len1;
      x2[d] = x1[d];
      if ($signed({x1[d], 1'b0}) < -len2) x2[d] = x1[d] + len1;
    end
    aa = sphere_radius_i * sphere_radius_i;
  end

  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      rowp_d[i] = '0;
      rowa_d[i] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        rowp_d[i] = rowp_d[i] + (ROW_W'(pp_q[i][j]) << (LIMB_W * j));
        rowa_d[i] = rowa_d[i] + (ROW_W'(ac_q[i][j]) << (LIMB_W * j));
      end
    end
    p2_d  = '0;
    avc_d = '0;
    for (int i = 0; i < NLIMB; i++) begin
      p2_d  = p2_d + (SQ_W'(rowp_q[i]) << (LIMB_W * i));
      avc_d = avc_d + (SQ_W'(rowa_q[i]) << (LIMB_W * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int d = 0; d < 3; d++) begin
        dx_q[d]  <= DV_W'($signed(pos_b_i[DAT_W*d +: DAT_W]))
                  - DV_W'($signed(pos_a_i[DAT_W*d +: DAT_W]));
        dv_q[d]  <= DV_W'($signed(vel_b_i[DAT_W*d +: DAT_W]))
                  - DV_W'($signed(vel_a_i[DAT_W*d +: DAT_W]));
        x_q[d]   <= x2[d];
        v_q[d]   <= dv_q[d];
        xv_q[d]  <= x_q[d] * v_q[d];
        vv_q[d]  <= v_q[d] * v_q[d];
        xxp_q[d] <= x_q[d] * x_q[d];
      end
      fa_q  <= {aa, 2'b00};
      p_q   <= SUM_W'(xv_q[0]) + SUM_W'(xv_q[1]) + SUM_W'(xv_q[2]);
      av5_q <= AV_W'($unsigned(vv_q[0])) + AV_W'($unsigned(vv_q[1]))
             + AV_W'($unsigned(vv_q[2]));
      c_q   <= SUM_W'(xxp_q[0]) + SUM_W'(xxp_q[1]) + SUM_W'(xxp_q[2])
             - $signed(SUM_W'(fa_q));
      pm_q      <= OP_W'(-p_q);
      cm_q      <= c_q[SUM_W-1] ? OP_W'(-c_q) : OP_W'(c_q);
      avx_q     <= OP_W'(av5_q);
      cneg_q[0] <= c_q[SUM_W-1];
      for (int i = 0; i < NLIMB; i++) begin
        for (int j = 0; j < NLIMB; j++) begin
          pp_q[i][j] <= pm_q[LIMB_W*i +: LIMB_W] * pm_q[LIMB_W*j +: LIMB_W];
          ac_q[i][j] <= avx_q[LIMB_W*i +: LIMB_W] * cm_q[LIMB_W*j +: LIMB_W];
        end
        rowp_q[i] <= rowp_d[i];
        rowa_q[i] <= rowa_d[i];
      end
      p2_q  <= p2_d;
      avc_q <= avc_d;
      q_q   <= cneg_q[3] ? $signed(Q_W'(p2_q)) + $signed(Q_W'(avc_q))
                         : $signed(Q_W'(p2_q)) - $signed(Q_W'(avc_q));
      pm_pipe_q[0] <= pm_q;
      av_pipe_q[0] <= avx_q[AV_W-1:0];
      for (int k = 1; k < 4; k++) begin
        cneg_q[k]    <= cneg_q[k-1];
        pm_pipe_q[k] <= pm_pipe_q[k-1];
        av_pipe_q[k] <= av_pipe_q[k-1];
      end
    end
  end

  always_comb begin
    meta_d[0] = meta_i;
    for (int k = 1; k < NST; k++) begin
      meta_d[k] = meta_q[k-1];
    end
    meta_d[ST_NEG].ok = meta_q[ST_NEG-1].ok & p_q[SUM_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) meta_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < NST; k++) meta_q[k] <= meta_d[k];
    end
  end

  assign meta_o = meta_q[NST-1];
  assign q_o    = q_q;
  assign m_o    = {pm_pipe_q[3], {FRAC_W{1'b0}}};
  assign av_o   = av_pipe_q[3];

endmodule

// ===== rtl/hspct_sqrt.sv =====
// Pipelined square root, one root bit per stage, rounded up.
`timescale 1ns / 1ps
module hspct_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  hspct_pkg::meta_t                 meta_i,
  input  logic signed [hspct_pkg::Q_W-1:0] q_i,
  input  logic [hspct_pkg::M_W-1:0]        m_i,
  input  logic [hspct_pkg::AV_W-1:0]       av_i,
  output hspct_pkg::meta_t                 meta_o,
  output logic [hspct_pkg::S_W-1:0]        s_o,
  output logic [hspct_pkg::M_W-1:0]        m_o,
  output logic [hspct_pkg::AV_W-1:0]       av_o
);
  import hspct_pkg::*;

  localparam int NS = RT_W + 1;

  meta_t              meta_q [NS];
  meta_t              meta_d [NS];
  logic [REM_W-1:0]   rem_q  [NS];
  logic [REM_W-1:0]   rem_d  [NS];
  logic [RT_W-1:0]    root_q [NS];
  logic [RT_W-1:0]    root_d [NS];
  logic [RADC_W-1:0]  rad_q  [NS];
  logic [RADC_W-1:0]  rad_d  [NS];
  logic [M_W-1:0]     m_q    [NS];
  logic [AV_W-1:0]    av_q   [NS];
  meta_t              meta_p_q;
  logic [S_W-1:0]     s_q;
  logic [M_W-1:0]     mp_q;
  logic [AV_W-1:0]    avp_q;

  always_comb begin
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    meta_d[0]    = meta_i;
    meta_d[0].ok = meta_i.ok & ~q_i[Q_W-1] & (|q_i);
    rem_d[0]     = '0;
    root_d[0]    = '0;
    rad_d[0]     = {q_i[RADC_W-2*FRAC_W-1:0], (2*FRAC_W)'(0)};
    for (int k = 0; k < RT_W; k++) begin
      meta_d[k+1] = meta_q[k];
      cur   = {rem_q[k][REM_W-3:0], rad_q[k][RADC_W-1 -: 2]};
      trial = REM_W'({root_q[k], 2'b01});
      if (cur >= trial) begin
        rem_d[k+1]  = cur - trial;
        root_d[k+1] = {root_q[k][RT_W-2:0], 1'b1};
      end else begin
        rem_d[k+1]  = cur;
        root_d[k+1] = {root_q[k][RT_W-2:0], 1'b0};
      end
      rad_d[k+1] = rad_q[k] << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
      m_q[0]  <= m_i;
      av_q[0] <= av_i;
      for (int k = 1; k < NS; k++) begin
        m_q[k]  <= m_q[k-1];
        av_q[k] <= av_q[k-1];
      end
      s_q   <= S_W'(root_q[NS-1]) + S_W'(|rem_q[NS-1]);
      mp_q  <= m_q[NS-1];
      avp_q <= av_q[NS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) meta_q[k] <= '0;
      meta_p_q <= '0;
    end else if (en_i) begin
      for (int k = 0; k < NS; k++) meta_q[k] <= meta_d[k];
      meta_p_q <= meta_q[NS-1];
    end
  end

  assign meta_o = meta_p_q;
  assign s_o    = s_q;
  assign m_o    = mp_q;
  assign av_o   = avp_q;

endmodule

// ===== rtl/hspct_div.sv =====
// Pipelined floor division of the root numerator by V.V, one quotient bit per stage, saturated.
`timescale 1ns / 1ps
module hspct_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  hspct_pkg::meta_t           meta_i,
  input  logic [hspct_pkg::S_W-1:0]  s_i,
  input  logic [hspct_pkg::M_W-1:0]  m_i,
  input  logic [hspct_pkg::AV_W-1:0] av_i,
  output hspct_pkg::meta_t           meta_o,
  output logic [hspct_pkg::T_W-1:0]  t_o
);
  import hspct_pkg::*;

  localparam int NS = MAG_W + 1;

  meta_t                 meta_n_q;
  logic signed [N_W-1:0] n_q;
  logic [AV_W-1:0]       avn_q;
  meta_t                 meta_q [NS];
  meta_t                 meta_d [NS];
  logic                  neg_q  [NS];
  logic [AV_W-1:0]       av_q   [NS];
  logic [DREM_W-1:0]     drem_q [NS];
  logic [DREM_W-1:0]     drem_d [NS];
  logic [MAG_W-1:0]      quo_q  [NS];
  logic [MAG_W-1:0]      quo_d  [NS];
  logic [MAG_W-1:0]      mag_q  [NS];
  meta_t                 meta_c_q;
  logic                  neg_c_q;
  logic [QUO_W-1:0]      quo_c_q;
  meta_t                 meta_t_q;
  logic [T_W-1:0]        t_q;
  logic [T_W-1:0]        t_d;

  always_comb begin
    logic [DREM_W-1:0] cur;
    meta_d[0] = meta_n_q;
    drem_d[0] = '0;
    quo_d[0]  = '0;
    for (int k = 0; k < MAG_W; k++) begin
      meta_d[k+1] = meta_q[k];
      cur = {drem_q[k][DREM_W-2:0], mag_q[k][MAG_W-1]};
      if (cur >= DREM_W'(av_q[k])) begin
        drem_d[k+1] = cur - DREM_W'(av_q[k]);
        quo_d[k+1]  = {quo_q[k][MAG_W-2:0], 1'b1};
      end else begin
        drem_d[k+1] = cur;
        quo_d[k+1]  = {quo_q[k][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    t_d = '0;
    if (meta_c_q.ok) begin
      if (neg_c_q) begin
        t_d = (quo_c_q > QUO_W'(T_MIN)) ? T_MIN : -quo_c_q[T_W-1:0];
      end else begin
        t_d = (quo_c_q > QUO_W'(T_MAX)) ? T_MAX : quo_c_q[T_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q      <= $signed(N_W'(m_i)) - $signed(N_W'(s_i));
      avn_q    <= av_i;
      neg_q[0] <= n_q[N_W-1];
      mag_q[0] <= n_q[N_W-1] ? MAG_W'(-n_q) : MAG_W'(n_q);
      av_q[0]  <= avn_q;
      for (int k = 0; k < NS; k++) begin
        drem_q[k] <= drem_d[k];
        quo_q[k]  <= quo_d[k];
      end
      for (int k = 1; k < NS; k++) begin
        neg_q[k] <= neg_q[k-1];
        av_q[k]  <= av_q[k-1];
        mag_q[k] <= mag_q[k-1] << 1;
      end
      neg_c_q <= neg_q[NS-1];
      quo_c_q <= QUO_W'(quo_q[NS-1]) + QUO_W'(neg_q[NS-1] & (|drem_q[NS-1]));
      t_q     <= t_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_n_q <= '0;
      for (int k = 0; k < NS; k++) meta_q[k] <= '0;
      meta_c_q <= '0;
      meta_t_q <= '0;
    end else if (en_i) begin
      meta_n_q <= meta_i;
      for (int k = 0; k < NS; k++) meta_q[k] <= meta_d[k];
      meta_c_q <= meta_q[NS-1];
      meta_t_q <= meta_c_q;
    end
  end

  assign meta_o = meta_t_q;
  assign t_o    = t_q;

endmodule

// ===== rtl/hard_sphere_pair_collision_time.sv =====
// Top level of the hard-sphere pair collision time block.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item per cycle. cmd_i load writes
//   particle index_a_i with its position and velocity; cmd_i query names the pair
//   index_a_i, index_b_i. Every item returns one result on the output channel
//   (out_valid_o/out_ready_i): hit_o, contact_time_o (signed Q32.16, saturated, zero
//   without a hit) and both indices echoed.
//   From acceptance to result valid an item passes the store read at the accepting
//   edge, nine geometry stages, 87 square root stages (one root bit per compute
//   stage), 90 division stages (one quotient bit per compute stage), output register.
//   Throughput is one item per cycle; a query may directly follow the load it reads.
//   Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) sets box_length and
//   sphere_radius; write it only while no item is in flight.
//   Reset clears all valid flags and sets box_length to 1.0 and sphere_radius to
//   3277/65536; particle entries hold nothing until loaded.
//   When the receiver stalls, the whole pipeline holds and in_ready_o drops until
//   the waiting result is taken.
module hard_sphere_pair_collision_time #(
  parameter int MAX_PARTICLES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [hspct_pkg::IDX_W-1:0] index_a_i,
  input  logic [hspct_pkg::IDX_W-1:0] index_b_i,
  input  logic [hspct_pkg::DAT_W-1:0] pos_x_i,
  input  logic [hspct_pkg::DAT_W-1:0] pos_y_i,
  input  logic [hspct_pkg::DAT_W-1:0] pos_z_i,
  input  logic [hspct_pkg::DAT_W-1:0] vel_x_i,
  input  logic [hspct_pkg::DAT_W-1:0] vel_y_i,
  input  logic [hspct_pkg::DAT_W-1:0] vel_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [hspct_pkg::T_W-1:0]   contact_time_o,
  output logic [hspct_pkg::IDX_W-1:0] first_index_o,
  output logic [hspct_pkg::IDX_W-1:0] second_index_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [hspct_pkg::CFG_W-1:0] cfg_wdata_i
);
  import hspct_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic              en;
  logic              accept;
  logic              a_in;
  logic              b_in;
  logic [LEN_W-1:0]  box_length_q;
  logic [RAD_W-1:0]  sphere_radius_q;
  meta_t             meta_s1_q;
  meta_t             meta_d;
  logic [VEC_W-1:0]  pos_a;
  logic [VEC_W-1:0]  pos_b;
  logic [VEC_W-1:0]  vel_a;
  logic [VEC_W-1:0]  vel_b;
  meta_t             meta_g;
  logic signed [Q_W-1:0] q_g;
  logic [M_W-1:0]    m_g;
  logic [AV_W-1:0]   av_g;
  meta_t             meta_r;
  logic [S_W-1:0]    s_r;
  logic [M_W-1:0]    m_r;
  logic [AV_W-1:0]   av_r;
  meta_t             meta_t_w;
  logic [T_W-1:0]    t_w;
  logic              out_valid_q;
  logic              hit_q;
  logic [T_W-1:0]    time_q;
  logic [IDX_W-1:0]  first_q;
  logic [IDX_W-1:0]  second_q;

  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i & en;
  assign a_in       = {{(32-IDX_W){1'b0}}, index_a_i} < 32'(MAX_PARTICLES);
  assign b_in       = {{(32-IDX_W){1'b0}}, index_b_i} < 32'(MAX_PARTICLES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_length_q    <= LEN_W'(65536);
      sphere_radius_q <= RAD_W'(3277);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_BOX_LENGTH:    box_length_q    <= cfg_wdata_i[LEN_W-1:0];
        REG_SPHERE_RADIUS: sphere_radius_q <= cfg_wdata_i[RAD_W-1:0];
        default:           box_length_q    <= box_length_q;
      endcase
    end
  end

  always_comb begin
    meta_d     = '0;
    meta_d.vld = accept;
    meta_d.ok  = (cmd_e'(cmd_i) == CMD_QUERY) & a_in & b_in;
    meta_d.ia  = index_a_i;
    meta_d.ib  = index_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_s1_q <= '0;
    end else if (en) begin
      meta_s1_q <= meta_d;
    end
  end

  hspct_store #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .AW           (AW)
  ) u_store (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (accept & (cmd_e'(cmd_i) == CMD_LOAD) & a_in),
    .waddr_i  (AW'(index_a_i)),
    .pos_i    ({pos_z_i, pos_y_i, pos_x_i}),
    .vel_i    ({vel_z_i, vel_y_i, vel_x_i}),
    .raddr_a_i(AW'(index_a_i)),
    .raddr_b_i(AW'(index_b_i)),
    .pos_a_o  (pos_a),
    .pos_b_o  (pos_b),
    .vel_a_o  (vel_a),
    .vel_b_o  (vel_b)
  );

  hspct_geom u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .meta_i         (meta_s1_q),
    .pos_a_i        (pos_a),
    .pos_b_i        (pos_b),
    .vel_a_i        (vel_a),
    .vel_b_i        (vel_b),
    .box_length_i   (box_length_q),
    .sphere_radius_i(sphere_radius_q),
    .meta_o         (meta_g),
    .q_o            (q_g),
    .m_o            (m_g),
    .av_o           (av_g)
  );

  hspct_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .meta_i(meta_g),
    .q_i   (q_g),
    .m_i   (m_g),
    .av_i  (av_g),
    .meta_o(meta_r),
    .s_o   (s_r),
    .m_o   (m_r),
    .av_o  (av_r)
  );

  hspct_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .meta_i(meta_r),
    .s_i   (s_r),
    .m_i   (m_r),
    .av_i  (av_r),
    .meta_o(meta_t_w),
    .t_o   (t_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= meta_t_w.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q    <= meta_t_w.ok;
      time_q   <= t_w;
      first_q  <= meta_t_w.ia;
      second_q <= meta_t_w.ib;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign contact_time_o = time_q;
  assign first_index_o  = first_q;
  assign second_index_o = second_q;

`ifndef SYNTHESIS
  a_no_hit_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> contact_time_o == '0)
    else $error("nonzero contact time without a hit");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |->
      ({{(32-IDX_W){1'b0}}, first_index_o} < 32'(MAX_PARTICLES)) &&
      ({{(32-IDX_W){1'b0}}, second_index_o} < 32'(MAX_PARTICLES)))
    else $error("hit reported for an index beyond the store");

  a_self_pair_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (first_index_o == second_index_o) |-> !hit_o)
    else $error("hit reported for a particle paired with itself");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(meta_s1_q))
    else $error("pipeline advanced while the result was stalled");
`endif

endmodule
